// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by the accumulator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with asynchronous active-low reset disable.
`define PIA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define PIA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pia_pkg.sv =====
// Types, constants and helper functions of the power injection accumulator.
package pia_pkg;

	localparam int CordicSteps = 16;
	localparam int IterW       = $clog2(CordicSteps);

	localparam logic signed [20:0] AngPi     = 21'sd205887;
	localparam logic signed [20:0] AngHalfPi = 21'sd102944;
	localparam logic signed [20:0] AngTwoPi  = 21'sd411775;
	localparam logic signed [17:0] CordicGain = 18'sd9949;

	localparam logic signed [65:0] W48Max = 66'sh0_0000_7FFF_FFFF_FFFF;
	localparam logic signed [65:0] W48Min = -W48Max - 66'sd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROT,
		S_GC,
		S_BS,
		S_TP,
		S_GS,
		S_BC,
		S_TQ,
		S_PLO,
		S_PHI,
		S_QLO,
		S_QHI,
		S_OUT
	} pia_state_t;

	typedef struct packed {
		logic        clip;
		logic [47:0] value;
	} sat_res_t;

	// Arctangent of 2^-i in Q16 radians.
	function automatic logic signed [20:0] atan_q16(input logic [IterW-1:0] i);
		logic signed [20:0] r;
		case (i)
			4'd0:    r = 21'sd51472;
			4'd1:    r = 21'sd30385;
			4'd2:    r = 21'sd16055;
			4'd3:    r = 21'sd8150;
			4'd4:    r = 21'sd4091;
			4'd5:    r = 21'sd2047;
			4'd6:    r = 21'sd1024;
			4'd7:    r = 21'sd512;
			4'd8:    r = 21'sd256;
			4'd9:    r = 21'sd128;
			4'd10:   r = 21'sd64;
			4'd11:   r = 21'sd32;
			4'd12:   r = 21'sd16;
			4'd13:   r = 21'sd8;
			4'd14:   r = 21'sd4;
			4'd15:   r = 21'sd2;
			default: r = 21'sd0;
		endcase
		return r;
	endfunction

	// Clip to the 48 bit signed range.
	function automatic sat_res_t sat48(input logic signed [65:0] v);
		sat_res_t r;
		if (v > W48Max) begin
			r.clip  = 1'b1;
			r.value = W48Max[47:0];
		end else if (v < W48Min) begin
			r.clip  = 1'b1;
			r.value = W48Min[47:0];
		end else begin
			r.clip  = 1'b0;
			r.value = v[47:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/pia_if.sv =====
// Channel interfaces: admittance entries in, bus injections out.
interface pia_entry_if;
	logic               valid;
	logic               ready;
	logic [9:0]         bus_index;
	logic signed [31:0] conductance;
	logic signed [31:0] susceptance;
	logic signed [15:0] angle_row;
	logic signed [15:0] angle_col;
	logic [15:0]        volt_col;
	logic [15:0]        volt_row;
	logic               last_in_row;

	modport source (output valid, bus_index, conductance, susceptance, angle_row,
		angle_col, volt_col, volt_row, last_in_row, input ready);
	modport sink (input valid, bus_index, conductance, susceptance, angle_row,
		angle_col, volt_col, volt_row, last_in_row, output ready);
endinterface

interface pia_result_if;
	logic               valid;
	logic               ready;
	logic [9:0]         out_bus;
	logic signed [47:0] p_calc;
	logic signed [47:0] q_calc;
	logic               saturated;

	modport source (output valid, out_bus, p_calc, q_calc, saturated, input ready);
	modport sink (input valid, out_bus, p_calc, q_calc, saturated, output ready);
endinterface

// ===== rtl/core/power_injection_accumulator_core.sv =====
// Channel   | Dir | Transfer                      | Payload
// entry     | in  | valid & ready                 | one nonzero admittance entry of a row
// result    | out | valid & ready                 | P and Q of a bus, on the last entry
// Each entry is latched, then runs 16 CORDIC rotations and 6 steps on the
// shared multiplier. The last entry of a row adds 4 scaling steps and one output step.
// The single 36x18 multiplier and the CORDIC shift-add loop set these counts.
// Reset clears the sums, the clip flag and the output valid flag; no clearing pass.
// A full output register holds the sequencer in its output step until the transfer.
`include "assert_macros.svh"

module power_injection_accumulator_core
	import pia_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	pia_entry_if.sink    entry,
	pia_result_if.source result
);

	pia_state_t state_q, state_d;

	logic [IterW-1:0]   iter_q;
	logic signed [17:0] x_q, y_q;
	logic signed [20:0] z_q;
	logic               flip_q;

	logic [9:0]         bus_q;
	logic signed [31:0] g_q, b_q;
	logic [15:0]        vc_q, vr_q;
	logic               last_q;

	logic signed [47:0] t_q;
	logic signed [65:0] f_q;
	logic signed [47:0] active_sum_q, reactive_sum_q;
	logic               clip_q;
	logic signed [47:0] p_q, q_q;

	logic               out_valid_q;
	logic [9:0]         out_bus_q;
	logic signed [47:0] out_p_q, out_q_q;
	logic               out_sat_q;

	logic               accept, out_free;
	logic signed [35:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [53:0] prod;
	logic signed [17:0] cval, sval;

	logic signed [16:0] dang;
	logic signed [20:0] z0, z1, z2, zr;
	logic               fl;

	logic signed [17:0] x_sh, y_sh;
	logic signed [20:0] atan_i;

	logic signed [39:0] term;
	logic signed [65:0] acc_sum, fsum;
	sat_res_t           acc_sat, fin_sat;

	assign accept   = entry.valid && entry.ready;
	assign out_free = !out_valid_q || result.ready;

	// Angle difference to Q16, reduce by whole turns, fold into [-pi/2, pi/2].
	always_comb begin
		dang = 17'(entry.angle_row) - 17'(entry.angle_col);
		z0   = 21'(dang) <<< 3;
		z1   = z0;
		if (z1 > AngPi) z1 = z1 - AngTwoPi;
		if (z1 < -AngPi) z1 = z1 + AngTwoPi;
		z2 = z1;
		if (z2 > AngPi) z2 = z2 - AngTwoPi;
		if (z2 < -AngPi) z2 = z2 + AngTwoPi;
		fl = 1'b0;
		zr = z2;
		if (z2 > AngHalfPi) begin
			zr = z2 - AngPi;
			fl = 1'b1;
		end else if (z2 < -AngHalfPi) begin
			zr = z2 + AngPi;
			fl = 1'b1;
		end
	end

	assign x_sh   = x_q >>> iter_q;
	assign y_sh   = y_q >>> iter_q;
	assign atan_i = atan_q16(iter_q);
	assign cval   = flip_q ? -x_q : x_q;
	assign sval   = flip_q ? -y_q : y_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_ROT;
			S_ROT:  if (iter_q == IterW'(CordicSteps - 1)) state_d = S_GC;
			S_GC:   state_d = S_BS;
			S_BS:   state_d = S_TP;
			S_TP:   state_d = S_GS;
			S_GS:   state_d = S_BC;
			S_BC:   state_d = S_TQ;
			S_TQ:   state_d = last_q ? S_PLO : S_IDLE;
			S_PLO:  state_d = S_PHI;
			S_PHI:  state_d = S_QLO;
			S_QLO:  state_d = S_QHI;
			S_QHI:  state_d = S_OUT;
			S_OUT:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and multiplier operand select.
	always_comb begin
		entry.ready = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		case (state_q)
			S_IDLE: entry.ready = 1'b1;
			S_GC: begin
				mul_a = 36'(g_q);
				mul_b = cval;
			end
			S_BS: begin
				mul_a = 36'(b_q);
				mul_b = sval;
			end
			S_GS: begin
				mul_a = 36'(g_q);
				mul_b = sval;
			end
			S_BC: begin
				mul_a = 36'(b_q);
				mul_b = cval;
			end
			S_TP, S_TQ: begin
				mul_a = 36'(t_q >>> 14);
				mul_b = $signed({2'b00, vc_q});
			end
			S_PLO: begin
				mul_a = $signed({12'd0, active_sum_q[23:0]});
				mul_b = $signed({2'b00, vr_q});
			end
			S_PHI: begin
				mul_a = 36'($signed(active_sum_q[47:24]));
				mul_b = $signed({2'b00, vr_q});
			end
			S_QLO: begin
				mul_a = $signed({12'd0, reactive_sum_q[23:0]});
				mul_b = $signed({2'b00, vr_q});
			end
			S_QHI: begin
				mul_a = 36'($signed(reactive_sum_q[47:24]));
				mul_b = $signed({2'b00, vr_q});
			end
			default: begin
				entry.ready = 1'b0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign term    = 40'(prod >>> 14);
	assign acc_sum = (state_q == S_TP) ? 66'(active_sum_q) + 66'(term)
		: 66'(reactive_sum_q) + 66'(term);
	assign acc_sat = sat48(acc_sum);
	assign fsum    = f_q + (66'(prod) <<< 24);
	assign fin_sat = sat48(fsum >>> 14);

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			iter_q         <= '0;
			active_sum_q   <= '0;
			reactive_sum_q <= '0;
			clip_q         <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ROT) iter_q <= iter_q + 1'b1;
			else iter_q <= '0;
			if (state_q == S_TP) begin
				active_sum_q <= acc_sat.value;
				clip_q       <= clip_q | acc_sat.clip;
			end
			if (state_q == S_TQ) begin
				reactive_sum_q <= acc_sat.value;
				clip_q         <= clip_q | acc_sat.clip;
			end
			if ((state_q == S_PHI) || (state_q == S_QHI)) clip_q <= clip_q | fin_sat.clip;
			if (result.valid && result.ready) out_valid_q <= 1'b0;
			if (state_q == S_OUT && out_free) begin
				out_valid_q    <= 1'b1;
				active_sum_q   <= '0;
				reactive_sum_q <= '0;
				clip_q         <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			bus_q  <= entry.bus_index;
			g_q    <= entry.conductance;
			b_q    <= entry.susceptance;
			vc_q   <= entry.volt_col;
			vr_q   <= entry.volt_row;
			last_q <= entry.last_in_row;
			z_q    <= zr;
			flip_q <= fl;
			x_q    <= CordicGain;
			y_q    <= '0;
		end
		if (state_q == S_ROT) begin
			// rotate toward zero residual angle
			if (!z_q[20]) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				z_q <= z_q - atan_i;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				z_q <= z_q + atan_i;
			end
		end
		case (state_q)
			S_GC, S_GS: t_q <= prod[47:0];
			S_BS:       t_q <= t_q + prod[47:0];
			S_BC:       t_q <= t_q - prod[47:0];
			S_PLO, S_QLO: f_q <= 66'(prod);
			S_PHI:      p_q <= fin_sat.value;
			S_QHI:      q_q <= fin_sat.value;
			default: begin
			end
		endcase
		if (state_q == S_OUT && out_free) begin
			out_bus_q <= bus_q;
			out_p_q   <= p_q;
			out_q_q   <= q_q;
			out_sat_q <= clip_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_bus   = out_bus_q;
	assign result.p_calc    = out_p_q;
	assign result.q_calc    = out_q_q;
	assign result.saturated = out_sat_q;

	`PIA_ASSERT(a_accept_starts_rot, clk, arst_n, accept |=> (state_q == S_ROT), "accept must start CORDIC")
	`PIA_ASSERT(a_rot_length, clk, arst_n, (state_q == S_ROT && iter_q == IterW'(CordicSteps - 1)) |=> (state_q == S_GC), "CORDIC must run a fixed number of steps")
	`PIA_ASSERT(a_sums_cleared, clk, arst_n, (state_q == S_OUT && out_free) |=> (active_sum_q == '0 && reactive_sum_q == '0 && !clip_q && out_valid_q), "row end must clear sums and show a result")

endmodule
